// File: rtl/gmh_pkg.sv
// Shared types and constants for the GF(2) matrix hash block.
// No dependencies; used by gmh_cell and gf2_matrix_hash_128.
package gmh_pkg;

  localparam int HASH_BYTES = 16;
  localparam int LANES      = 8;
  localparam int IDX_W      = 4;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_lane;
    logic [7:0] wr_data;
    logic       rd_en;
    logic       upd;
    logic [7:0] data;
    logic       shift;
  } cell_ctrl_t;

endpackage

// File: rtl/gmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/gmh_cell.sv
// One hash byte: eight key rows in RAM, their parity accumulator, and a
// shift link to the neighbor cell. Depends on gmh_pkg and gmh_ram.
module gmh_cell #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gmh_pkg::cell_ctrl_t ctrl,
  input  logic [AW-1:0]       wr_addr,
  input  logic [AW-1:0]       rd_addr,
  input  logic [7:0]          shift_in,
  output logic [7:0]          acc
);

  logic [7:0] rd_data [gmh_pkg::LANES];
  logic [7:0] par;
  logic [7:0] acc_r;
  logic [7:0] acc_nxt;

  for (genvar j = 0; j < gmh_pkg::LANES; j++) begin : g_lane
    gmh_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk     (clk),
      .wr_en   (ctrl.wr_en && (ctrl.wr_lane == 3'(j))),
      .wr_addr (wr_addr),
      .wr_data (ctrl.wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data[j])
    );
    // hash bit 8k+j sits at bit 7-j of the output byte
    assign par[7-j] = ^(ctrl.data & rd_data[j]);
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.shift) begin
      acc_nxt = shift_in;
    end else if (ctrl.upd) begin
      acc_nxt = acc_r ^ par;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 8'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: rtl/gf2_matrix_hash_128.sv
// Top level of the 128-bit GF(2) matrix hash: control, row counter and a
// chain of 16 gmh_cell instances. Depends on gmh_pkg, gmh_cell, gmh_ram.
//
//   port group   dir   beat contents
//   in_*         in    tuser: opcode; tdata: key_row, key_pos, value
//   out_*        out   tdata: hash_byte, hash_index; tlast: last
//   cfg_*        in    row_len, written when cfg_wr_en is high
//
// Key writes and data bytes are accepted one per cycle while in_tready is high and may follow back to back.
// After the final byte of a row the registered key read is folded in, then
// 16 out beats shift down the cell chain; in_tready is low meanwhile.
// out_tready stalls hold the chain. Reset clears control and accumulators;
// the key store is not cleared.
module gf2_matrix_hash_128 #(
  parameter int MAX_ROW_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_row[6:0], key_pos[12:7], value[20:13]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // hash_byte[7:0], hash_index[11:8]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int AW  = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int CAP = (MAX_ROW_LEN < 64) ? MAX_ROW_LEN : 64;
  localparam logic [6:0] CAP_LEN = 7'(CAP);
  localparam logic [gmh_pkg::IDX_W-1:0] IDX_LAST = gmh_pkg::IDX_W'(gmh_pkg::HASH_BYTES - 1);

  logic [6:0] key_row;
  logic [5:0] key_pos;
  logic [7:0] value;
  logic       in_fire, out_fire, is_data, key_ok, pos_ok, row_end;
  logic [6:0] len_eff;

  logic [6:0] row_len_r;
  logic [5:0] byte_pos_r, byte_pos_nxt;
  logic       pend_r, pend_ok_r, pend_last_r;
  logic [7:0] pend_data_r;
  logic       unload_r, unload_nxt;
  logic [gmh_pkg::IDX_W-1:0] idx_r, idx_nxt;

  gmh_pkg::cell_ctrl_t ctrl [gmh_pkg::HASH_BYTES];
  logic [7:0] acc [gmh_pkg::HASH_BYTES];

  assign key_row = in_tdata[6:0];
  assign key_pos = in_tdata[12:7];
  assign value   = in_tdata[20:13];

  assign in_tready = !unload_r && !pend_last_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign is_data   = (in_tuser == gmh_pkg::OP_DATA);
  assign key_ok    = int'(key_pos) < MAX_ROW_LEN;
  assign pos_ok    = int'(byte_pos_r) < MAX_ROW_LEN;

  always_comb begin
    len_eff = row_len_r;
    if (row_len_r == 7'd0) begin
      len_eff = 7'd1;
    end else if (row_len_r > CAP_LEN) begin
      len_eff = CAP_LEN;
    end
  end

  assign row_end = ({1'b0, byte_pos_r} + 7'd1) >= len_eff;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    if (in_fire && is_data) begin
      byte_pos_nxt = row_end ? 6'd0 : byte_pos_r + 6'd1;
    end
    unload_nxt = unload_r;
    idx_nxt    = idx_r;
    if (pend_last_r) begin
      unload_nxt = 1'b1;
    end
    if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == IDX_LAST) begin
        unload_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r   <= 7'd1;
      byte_pos_r  <= 6'd0;
      pend_r      <= 1'b0;
      pend_ok_r   <= 1'b0;
      pend_last_r <= 1'b0;
      unload_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_len_r <= cfg_wr_data;
      end
      byte_pos_r  <= byte_pos_nxt;
      pend_r      <= in_fire && is_data;
      pend_ok_r   <= in_fire && is_data && pos_ok;
      pend_last_r <= in_fire && is_data && row_end;
      unload_r    <= unload_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_data) begin
      pend_data_r <= value;
    end
  end

  for (genvar k = 0; k < gmh_pkg::HASH_BYTES; k++) begin : g_cell
    always_comb begin
      ctrl[k].wr_en   = in_fire && !is_data && key_ok && (key_row[6:3] == 4'(k));
      ctrl[k].wr_lane = key_row[2:0];
      ctrl[k].wr_data = value;
      ctrl[k].rd_en   = in_fire && is_data;
      ctrl[k].upd     = pend_r && pend_ok_r;
      ctrl[k].data    = pend_data_r;
      ctrl[k].shift   = out_fire;
    end

    gmh_cell #(.DEPTH(MAX_ROW_LEN)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[k]),
      .wr_addr  (AW'(key_pos)),
      .rd_addr  (AW'(byte_pos_r)),
      .shift_in ((k < gmh_pkg::HASH_BYTES - 1) ? acc[(k + 1) % gmh_pkg::HASH_BYTES] : 8'd0),
      .acc      (acc[k])
    );
  end

  assign out_tvalid = unload_r;
  assign out_tdata  = {4'd0, idx_r, acc[0]};
  assign out_tlast  = (idx_r == IDX_LAST);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while hash is unloading");

  a_unload_start: assert property (@(posedge clk) disable iff (!rst_n)
    pend_last_r |=> out_tvalid && (out_tdata[11:8] == 4'd0))
    else $error("unload did not start at byte 0 after row end");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> !out_tvalid && (out_tdata == 16'd0))
    else $error("accumulator or index not cleared after last beat");

  a_no_update_unload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !pend_r)
    else $error("parity update during unload");

endmodule
